// ===== sv/erd_pkg.sv =====
// Package for the elliptical radial distance block: field widths,
// register index codes and fixed-point constants.
// No dependencies.
package erd_pkg;

  localparam int COORD_W  = 24;
  localparam int DIFF_W   = 25;
  localparam int TRIG_W   = 16;
  localparam int INV_W    = 24;
  localparam int CFG_W    = 24;
  localparam int INDEX_W  = 3;
  localparam int PROD_W   = DIFF_W + TRIG_W;
  localparam int ROT_W    = PROD_W + 1;
  localparam int MAG_W    = 28;
  localparam int SQ_W     = 2 * MAG_W;
  localparam int SUM_W    = 48;
  localparam int RADIUS_W = 24;
  localparam int ROUND_SH = 14;

  typedef enum logic [INDEX_W-1:0] {
    REG_CENTER_X  = 3'd0,
    REG_CENTER_Y  = 3'd1,
    REG_COS_THETA = 3'd2,
    REG_SIN_THETA = 3'd3,
    REG_INV_RATIO = 3'd4
  } reg_index_t;

  localparam logic signed [TRIG_W-1:0] COS_RESET   = 16'sd16384;
  localparam logic [INV_W-1:0]         RATIO_RESET = 24'd65536;

endpackage

// ===== sv/elliptical_radial_distance.sv =====
// Top level of the elliptical radial distance block: a fully pipelined
// datapath from pixel coordinates to a saturated Q16.8 radius.
// Depends on erd_pkg.
//
// Usage: software writes the ellipse center, the rotation (cos and sin in
// Q1.14) and 1/q^2 in Q8.16 through the write port while no word is in
// flight. Pixel coordinates then enter on the input channel as words of
// pixel_x and pixel_y; each produces one output word of radius and a
// saturated flag, in order.
// There are 32 register stages: eight arithmetic stages (difference,
// rotation products, rotation sums, rounding, squares, axis scaling, term
// assembly, final sum) and one square-root stage per result bit, 24 in all.
// One word can enter every cycle while the receiver keeps out_ready high;
// throughput is then one word per cycle, since every stage is registered
// and a stage loads while its own word moves on.
// Reset clears every valid bit and loads the default rotation (angle zero)
// and axis ratio of one, with the center at the origin.
// When the receiver holds out_ready low, stages keep their words and empty
// stages still fill, so in_ready falls only once every stage holds a word.
module elliptical_radial_distance (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [erd_pkg::INDEX_W-1:0]          cfg_index,
  input  logic [erd_pkg::CFG_W-1:0]            cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [erd_pkg::COORD_W-1:0]   pixel_x,
  input  logic signed [erd_pkg::COORD_W-1:0]   pixel_y,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [erd_pkg::RADIUS_W-1:0]         radius,
  output logic                                 saturated
);
  import erd_pkg::*;

  localparam int SQRT_STAGES = RADIUS_W;
  localparam int PRE_STAGES  = 8;
  localparam int NST         = PRE_STAGES + SQRT_STAGES;

  logic signed [COORD_W-1:0] center_x;
  logic signed [COORD_W-1:0] center_y;
  logic signed [TRIG_W-1:0]  cos_theta;
  logic signed [TRIG_W-1:0]  sin_theta;
  logic [INV_W-1:0]          inv_axis_ratio_sq;

  logic [NST-1:0] v;
  logic [NST-1:0] adv;

  logic signed [DIFF_W-1:0] dx, dy;
  logic signed [PROD_W-1:0] p_xc, p_ys, p_yc, p_xs;
  logic signed [ROT_W-1:0]  major, minor;
  logic [MAG_W-1:0]         mj, mn;
  logic [SQ_W-1:0]          maj2, min2;
  logic [SQ_W-1:0]          maj2_s5, maj2_s6;
  logic [47:0]              hp;
  logic [55:0]              lp;
  logic [64:0]              term;
  logic [ROT_W-1:0]         maj_abs, min_abs;
  logic [65:0]              total;

  logic [SUM_W-1:0]    rem_q  [0:SQRT_STAGES];
  logic [RADIUS_W-1:0] root_q [0:SQRT_STAGES];
  logic                sat_q  [0:SQRT_STAGES];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x          <= '0;
      center_y          <= '0;
      cos_theta         <= COS_RESET;
      sin_theta         <= '0;
      inv_axis_ratio_sq <= RATIO_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTER_X:  center_x          <= cfg_data;
        REG_CENTER_Y:  center_y          <= cfg_data;
        REG_COS_THETA: cos_theta         <= cfg_data[TRIG_W-1:0];
        REG_SIN_THETA: sin_theta         <= cfg_data[TRIG_W-1:0];
        REG_INV_RATIO: inv_axis_ratio_sq <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // A stage takes a new word when it is empty or its own word moves on.
  assign adv[NST-1] = !v[NST-1] || out_ready;
  for (genvar k = 0; k < NST - 1; k++) begin : g_adv
    assign adv[k] = !v[k] || adv[k+1];
  end

  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (adv[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // The rounded magnitude of a negative sum is (~v + 1) + 2^13, taken as one add.
  always_comb begin
    maj_abs = major[ROT_W-1] ? ~major : major;
    min_abs = minor[ROT_W-1] ? ~minor : minor;
    maj_abs = maj_abs + (major[ROT_W-1] ? ROT_W'(8193) : ROT_W'(8192));
    min_abs = min_abs + (minor[ROT_W-1] ? ROT_W'(8193) : ROT_W'(8192));
  end

  assign total = 66'(maj2_s6) + 66'(term);

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      dx <= DIFF_W'(center_x) - DIFF_W'(pixel_x);
      dy <= DIFF_W'(center_y) - DIFF_W'(pixel_y);
    end
    if (adv[1]) begin
      p_xc <= dx * cos_theta;
      p_ys <= dy * sin_theta;
      p_yc <= dy * cos_theta;
      p_xs <= dx * sin_theta;
    end
    if (adv[2]) begin
      major <= ROT_W'(p_xc) + ROT_W'(p_ys);
      minor <= ROT_W'(p_yc) - ROT_W'(p_xs);
    end
    if (adv[3]) begin
      mj <= maj_abs[ROT_W-1:ROUND_SH];
      mn <= min_abs[ROT_W-1:ROUND_SH];
    end
    if (adv[4]) begin
      maj2 <= mj * mj;
      min2 <= mn * mn;
    end
    if (adv[5]) begin
      hp      <= min2[SQ_W-1:32] * inv_axis_ratio_sq;
      lp      <= min2[31:0] * inv_axis_ratio_sq;
      maj2_s5 <= maj2;
    end
    if (adv[6]) begin
      term    <= 65'({hp, 16'b0}) + 65'(lp[55:16]);
      maj2_s6 <= maj2_s5;
    end
    if (adv[7]) begin
      rem_q[0]  <= total[SUM_W-1:0];
      root_q[0] <= '0;
      sat_q[0]  <= |total[65:SUM_W];
    end
  end

  // Square root, one result bit per stage, most significant bit first.
  for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_sqrt
    localparam int B = SQRT_STAGES - 1 - j;
    logic [SUM_W:0] trial;
    logic           fits;

    always_comb begin
      trial = ((SUM_W+1)'(root_q[j]) << (B + 1)) + ((SUM_W+1)'(1) << (2 * B));
      fits  = {1'b0, rem_q[j]} >= trial;
    end

    always_ff @(posedge clk) begin
      if (adv[PRE_STAGES+j]) begin
        rem_q[j+1]  <= fits ? rem_q[j] - trial[SUM_W-1:0] : rem_q[j];
        root_q[j+1] <= fits ? root_q[j] | (RADIUS_W'(1) << B) : root_q[j];
        sat_q[j+1]  <= sat_q[j];
      end
    end
  end

  assign out_valid = v[NST-1];
  assign saturated = sat_q[SQRT_STAGES];
  assign radius    = sat_q[SQRT_STAGES] ? '1 : root_q[SQRT_STAGES];

endmodule

// ===== tb/elliptical_radial_distance_test.sv =====
// Self-checking testbench for the elliptical radial distance block.
// Holds a scoreboard class that predicts each radius word and drives the block
// through directed and random pixels under several register settings; needs erd_pkg.
`timescale 1ns / 100ps

module elliptical_radial_distance_test;
  import erd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_PHASES = 12;
  localparam int PIXELS_PER_PHASE = 161;
  localparam logic [INDEX_W-1:0] REG_NONE = 3'd7;
  localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;

  typedef struct packed {
    logic [RADIUS_W-1:0] radius;
    logic saturated;
  } radius_word_t;

  class radius_scoreboard;
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [TRIG_W-1:0] cos_q14;
    logic signed [TRIG_W-1:0] sin_q14;
    logic [INV_W-1:0] inv_ratio_sq;
    radius_word_t pending_radius[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned saturations;
    int unsigned settings;

    function new();
      center_x = '0;
      center_y = '0;
      cos_q14 = COS_RESET;
      sin_q14 = '0;
      inv_ratio_sq = RATIO_RESET;
    endfunction

    function void write_register(logic [INDEX_W-1:0] index, logic [CFG_W-1:0] data);
      case (index)
        REG_CENTER_X: center_x = data;
        REG_CENTER_Y: center_y = data;
        REG_COS_THETA: cos_q14 = data[TRIG_W-1:0];
        REG_SIN_THETA: sin_q14 = data[TRIG_W-1:0];
        REG_INV_RATIO: inv_ratio_sq = data;
        default: ;
      endcase
    endfunction

    // Rounds the magnitude of a Q.22 value to Q.8, half away from zero.
    function longint unsigned round_to_q8(longint v);
      longint unsigned mag;
      mag = (v < 0) ? longint'(-v) : longint'(v);
      return (mag + (64'd1 << (ROUND_SH - 1))) >> ROUND_SH;
    endfunction

    function void note_pixel(logic signed [COORD_W-1:0] px, logic signed [COORD_W-1:0] py);
      longint dx, dy, major, minor;
      longint unsigned mj, mn, rem, root, bit_q;
      logic [79:0] total;
      radius_word_t word;
      dx = longint'(center_x) - longint'(px);
      dy = longint'(center_y) - longint'(py);
      major = dx * longint'(cos_q14) + dy * longint'(sin_q14);
      minor = dy * longint'(cos_q14) - dx * longint'(sin_q14);
      mj = round_to_q8(major);
      mn = round_to_q8(minor);
      total = 80'(mj * mj) + ((80'(mn * mn) * 80'(inv_ratio_sq)) >> 16);
      if (total >= (80'd1 << SUM_W)) begin
        word.radius = '1;
        word.saturated = 1'b1;
        saturations++;
      end else begin
        rem = total[63:0];
        root = 0;
        bit_q = 64'd1 << 46;
        while (bit_q != 0) begin
          if (rem >= root + bit_q) begin
            rem -= root + bit_q;
            root = (root >> 1) + bit_q;
          end else begin
            root >>= 1;
          end
          bit_q >>= 2;
        end
        word.radius = root[RADIUS_W-1:0];
        word.saturated = 1'b0;
      end
      pending_radius.push_back(word);
    endfunction

    function void check_radius(logic [RADIUS_W-1:0] r, logic s);
      radius_word_t want;
      checked++;
      if (pending_radius.size() == 0) begin
        $error("radius word %0d arrived with no pixel pending", r);
        errors++;
        return;
      end
      want = pending_radius.pop_front();
      if (r !== want.radius) begin
        $error("radius: expected %0d, actual %0d", want.radius, r);
        errors++;
      end
      if (s !== want.saturated) begin
        $error("saturated: expected %0b, actual %0b", want.saturated, s);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [INDEX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [COORD_W-1:0] pixel_x = '0;
  logic signed [COORD_W-1:0] pixel_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [RADIUS_W-1:0] radius;
  logic saturated;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int stall_cycles = 0;
  radius_scoreboard board = new();

  elliptical_radial_distance u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .pixel_x(pixel_x),
    .pixel_y(pixel_y),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .radius(radius),
    .saturated(saturated)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      board.check_radius(radius, saturated);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_register(logic [INDEX_W-1:0] index, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    board.write_register(index, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_setting(logic [CFG_W-1:0] cx, logic [CFG_W-1:0] cy,
                              logic [TRIG_W-1:0] c, logic [TRIG_W-1:0] s,
                              logic [INV_W-1:0] inv);
    write_register(REG_CENTER_X, cx);
    write_register(REG_CENTER_Y, cy);
    write_register(REG_COS_THETA, {8'($urandom), c});
    write_register(REG_SIN_THETA, {8'($urandom), s});
    write_register(REG_INV_RATIO, inv);
    board.settings++;
  endtask

  task automatic send_pixel(logic signed [COORD_W-1:0] px, logic signed [COORD_W-1:0] py);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    pixel_x <= px;
    pixel_y <= py;
    do @(posedge clk); while (!in_ready);
    board.note_pixel(px, py);
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending_radius.size() != 0) @(posedge clk);
  endtask

  initial begin
    int pick;
    int span;
    logic signed [COORD_W-1:0] px, py;
    logic [TRIG_W-1:0] c, s;
    logic [INV_W-1:0] inv;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset setting: field extremes and small offsets.
    send_pixel(24'sd0, 24'sd0);
    send_pixel(COORD_MAX, COORD_MAX);
    send_pixel(COORD_MIN, COORD_MIN);
    send_pixel(COORD_MAX, COORD_MIN);
    send_pixel(COORD_MIN, COORD_MAX);
    send_pixel(24'sd1, -24'sd1);
    send_pixel(-24'sd1, 24'sd1);
    drain();

    // Extreme center, rotation of -2.0 and the largest axis scale: saturation and zero.
    load_setting(COORD_MAX, COORD_MIN, 16'h8000, 16'h7FFF, 24'hFFFFFF);
    send_pixel(COORD_MIN, COORD_MAX);
    send_pixel(COORD_MAX, COORD_MIN);
    send_pixel(24'sd0, 24'sd0);
    drain();

    // Tiny rotation terms hit the rounding boundary exactly; a zero axis scale
    // drops the minor term, and writes to an unused index must change nothing.
    load_setting(24'd0, 24'd0, 16'd1, 16'hFFFF, 24'd0);
    write_register(REG_NONE, 24'hFFFFFF);
    send_pixel(-24'sd8192, 24'sd0);
    send_pixel(24'sd8192, 24'sd0);
    send_pixel(-24'sd8191, 24'sd0);
    drain();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: load_setting(24'd0, 24'd0, COS_RESET, 16'd0, RATIO_RESET);
        1: load_setting(COORD_MAX, COORD_MAX, 16'd16384, 16'd16384, 24'hFFFFFF);
        2: load_setting(COORD_MIN, COORD_MIN, -16'sd16384, -16'sd16384, 24'd65536);
        3: load_setting(24'($urandom), 24'($urandom), 16'h8000, 16'h7FFF, 24'd0);
        default: begin
          c = 16'($urandom_range(32768)) - 16'd16384;
          s = 16'($urandom_range(32768)) - 16'd16384;
          if ($urandom_range(3) == 0) begin
            c = 16'($urandom);
            s = 16'($urandom);
          end
          inv = ($urandom_range(3) == 0) ? 24'($urandom_range(65535))
                                          : 24'($urandom_range(16777215, 65536));
          load_setting(24'($urandom), 24'($urandom), c, s, inv);
        end
      endcase
      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 60;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 60;
        end
        default: begin
          send_idle_pct = 18;
          recv_stall_pct = 18;
        end
      endcase
      for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
        pick = $urandom_range(9);
        span = (pick < 6) ? 4096 : 262144;
        if (pick < 3) begin
          px = COORD_W'($urandom);
          py = COORD_W'($urandom);
        end else if (pick < 9) begin
          px = board.center_x - 24'($urandom_range(2 * span) - span);
          py = board.center_y - 24'($urandom_range(2 * span) - span);
        end else begin
          px = $urandom_range(1) ? COORD_MAX : COORD_MIN;
          py = $urandom_range(1) ? COORD_MAX : COORD_MIN;
        end
        send_pixel(px, py);
      end
      drain();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Compared %0d radius words under %0d register settings and four handshake mixes.",
             board.checked, board.settings);
    $display("%0d of the predicted words were saturated.", board.saturations);
    if (board.errors == 0 && board.pending_radius.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
